@@ src/ptct_pkg.sv @@
package ptct_pkg;

    localparam int ID_W  = 32;
    localparam int CNT_W = 16;
    localparam int IDX_W = 4;

    // Input selector codes carried on s_tuser.
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result kind codes carried on m_tuser.
    localparam logic [1:0] KIND_FIRED  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ADD    = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] period;
        logic [ID_W-1:0]  id;
    } slot_t;

    typedef struct packed {
        logic occupied;
        logic due;
        logic match;
    } cell_stat_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } state_t;

endpackage

@@ src/ptct_cell.sv @@
module ptct_cell
    import ptct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_op_t            op,
    input  slot_t               shift_in,
    input  logic [ID_W-1:0]     load_id,
    input  logic [CNT_W-1:0]    load_period,
    input  logic [ID_W-1:0]     cmp_id,
    output slot_t               q,
    output slot_t               aged,
    output cell_stat_t          stat
);

    slot_t slot_reg;
    slot_t slot_next;

    assign q = slot_reg;

    always_comb
    begin
        stat.occupied = (slot_reg.id != '0);
        stat.due      = stat.occupied && (slot_reg.count == '0);
        stat.match    = (slot_reg.id == cmp_id);

        // What this slot becomes after one tick: reload when due, else count down.
        aged = slot_reg;
        if (stat.due)
        begin
            aged.count = slot_reg.period;
        end
        else if (stat.occupied)
        begin
            aged.count = slot_reg.count - 1'b1;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        unique case (op)
            CELL_HOLD:  slot_next = slot_reg;
            CELL_SHIFT: slot_next = shift_in;
            CELL_LOAD:
            begin
                slot_next.count  = '0;
                slot_next.period = load_period;
                slot_next.id     = load_id;
            end
            default:    slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

@@ src/periodic_callback_timer_table.sv @@
// Periodic timer table with SLOTS slots, each a countdown, a reload period and a callback id.
//
// Input channel s_*: s_tuser selects tick, add or remove; s_tdata carries the callback id
// and the period. Output channel m_*: m_tuser gives the result kind, m_tlast closes the
// results of one input item.
//
// Add and remove finish in the cycle they are accepted; the result is valid on the next
// cycle, and the next item may follow as soon as that result is taken or at the same edge.
// A tick rotates the whole row of slots through slot 0 one position per cycle while the
// output register is free, where the slot is aged and a fired item is produced if it was
// due. Once every slot has passed through slot 0, a done item closes the tick.
//
// Reset clears every slot to empty and empties the output register. When the receiver
// stalls, the rotation halts with it and no item is accepted until the tick is complete
// and its done item can be loaded.
module periodic_callback_timer_table
    import ptct_pkg::*;
#(
    parameter int SLOTS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // callback_id [31:0], period_ticks [47:32]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fired_id [31:0], slot_index [35:32], failed [36], zero
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast    // last
);

    localparam int STEP_W = $clog2(SLOTS + 1);

    slot_t      cell_q    [SLOTS];
    slot_t      cell_aged [SLOTS];
    slot_t      cell_in   [SLOTS];
    cell_op_t   cell_op   [SLOTS];
    cell_stat_t cell_stat [SLOTS];
    logic       add_sel   [SLOTS];
    logic       rm_shift  [SLOTS];

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_fail_reg, out_fail_next;
    logic               out_last_reg, out_last_next;

    logic [ID_W-1:0]    in_id;
    logic [CNT_W-1:0]   in_period;
    logic               out_free;
    logic               accept;
    logic               rotate;
    logic               free_seen, match_seen;
    logic [IDX_W-1:0]   add_idx, rm_idx;
    logic               add_ok, rm_ok;
    slot_t              tail_in;

    assign in_id     = s_tdata[31:0];
    assign in_period = s_tdata[47:32];
    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign rotate    = (state_reg == ST_TICK) && out_free && (step_reg != STEP_W'(SLOTS));

    // During a tick the aged head wraps round to the tail; a remove pulls in an empty slot.
    assign tail_in = (state_reg == ST_TICK) ? cell_aged[0] : '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            if (g < SLOTS - 1)
            begin : g_mid
                assign cell_in[g] = cell_q[g + 1];
            end
            else
            begin : g_tail
                assign cell_in[g] = tail_in;
            end

            ptct_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op[g]),
                .shift_in    (cell_in[g]),
                .load_id     (in_id),
                .load_period (in_period),
                .cmp_id      (in_id),
                .q           (cell_q[g]),
                .aged        (cell_aged[g]),
                .stat        (cell_stat[g])
            );
        end
    endgenerate

    // First free slot for add, and the first match plus everything after it for remove.
    always_comb
    begin
        free_seen  = 1'b0;
        match_seen = 1'b0;
        add_idx    = '0;
        rm_idx     = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            add_sel[i] = !cell_stat[i].occupied && !free_seen;
            if (add_sel[i])
            begin
                add_idx = IDX_W'(i);
            end
            free_seen = free_seen || !cell_stat[i].occupied;

            if (cell_stat[i].match && !match_seen)
            begin
                rm_idx = IDX_W'(i);
            end
            match_seen  = match_seen || cell_stat[i].match;
            rm_shift[i] = match_seen;
        end
        add_ok = free_seen && (in_id != '0);
        rm_ok  = match_seen && (in_id != '0);
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (rotate)
            begin
                cell_op[i] = CELL_SHIFT;
            end
            else if (accept && (s_tuser == MODE_ADD) && add_ok && add_sel[i])
            begin
                cell_op[i] = CELL_LOAD;
            end
            else if (accept && (s_tuser == MODE_REMOVE) && rm_ok && rm_shift[i])
            begin
                cell_op[i] = CELL_SHIFT;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_idx_next   = out_idx_reg;
        out_fail_next  = out_fail_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (accept)
                begin
                    unique case (s_tuser)
                        MODE_TICK:
                        begin
                            state_next = ST_TICK;
                            step_next  = '0;
                        end
                        MODE_ADD:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ADD;
                            out_id_next    = '0;
                            out_idx_next   = add_ok ? add_idx : '0;
                            out_fail_next  = !add_ok;
                            out_last_next  = 1'b1;
                        end
                        MODE_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_REMOVE;
                            out_id_next    = '0;
                            out_idx_next   = rm_ok ? rm_idx : '0;
                            out_fail_next  = !rm_ok;
                            out_last_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    if (step_reg == STEP_W'(SLOTS))
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_DONE;
                        out_id_next    = '0;
                        out_idx_next   = '0;
                        out_fail_next  = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                        if (cell_stat[0].due)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_FIRED;
                            out_id_next    = cell_q[0].id;
                            out_idx_next   = IDX_W'(step_reg);
                            out_fail_next  = 1'b0;
                            out_last_next  = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_idx_reg  <= out_idx_next;
        out_fail_reg <= out_fail_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_fail_reg, out_idx_reg, out_id_reg};

endmodule

@@ src/ptct_checker.sv @@
module ptct_checker
    import ptct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // A waiting result item stays offered until it is taken.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result item dropped while stalled");

    // An add or remove answers with exactly one closing item on the next cycle.
    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_ADD || s_tuser == MODE_REMOVE))
        |=> (m_tvalid && m_tlast && (m_tuser == KIND_ADD || m_tuser == KIND_REMOVE)))
        else $error("add or remove result missing");

    // A tick keeps the input closed at least until its walk has started.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_TICK) |=> !s_tready)
        else $error("input accepted during a tick");

    // Fired items are never final and never flag a failure.
    a_fired_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_FIRED) |-> (!m_tlast && !m_tdata[36]))
        else $error("malformed fired item");

endmodule

bind periodic_callback_timer_table ptct_checker u_ptct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
